// ===== rtl/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque
// Opcode and status codes, ring geometry and the request word that the
// pointer control hands to the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [DATA_WIDTH-1:0] word_t;

	// One accepted operation as seen by the ring memory and the result stage.
	typedef struct packed {
		logic    wr_en;
		idx_t    wr_addr;
		logic    rd_en;
		idx_t    rd_addr;
		status_t status;
	} ring_req_t;

	function automatic idx_t wrap_next(input idx_t i);
		return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
	endfunction

	function automatic idx_t wrap_prev(input idx_t i);
		return (i == '0) ? LAST_IDX : idx_t'(i - 1'b1);
	endfunction

	// The port carries 32 bits; the ring keeps DATA_WIDTH of them.
	function automatic word_t to_store(input logic [31:0] d);
		logic [63:0] w;
		w = {32'b0, d};
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] from_store(input word_t x);
		logic [63:0] w;
		w = 64'(x);
		return w[31:0];
	endfunction

endpackage

// ===== rtl/cdq_ring_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ring_ram: single-port-write, single-port-read ring storage
// Synchronous memory with a registered read port.
// ----------------------------------------------------------------------------
module cdq_ring_ram #(
	parameter int Depth = 16,
	parameter int Width = 32,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  logic [Width-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl: front/rear pointer control of the circular deque
// Decodes each accepted operation, updates the pointers and the empty flag
// and issues the ring write or read it needs, together with its status.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [2:0] opcode,
	output ring_req_t  req
);

	idx_t front_q, rear_q;
	logic empty_q;
	idx_t front_d, rear_d;
	logic empty_d;
	logic full;
	logic last_one;

	assign full     = !empty_q && (wrap_next(rear_q) == front_q);
	assign last_one = (front_q == rear_q);

	always_comb begin
		front_d     = front_q;
		rear_d      = rear_q;
		empty_d     = empty_q;
		req.wr_en   = 1'b0;
		req.wr_addr = '0;
		req.rd_en   = 1'b0;
		req.rd_addr = '0;
		req.status  = ST_OK;
		unique case (opcode) inside
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (full) begin
					req.status = ST_OVERFLOW;
				end else if (empty_q) begin
					empty_d   = 1'b0;
					front_d   = '0;
					rear_d    = '0;
					req.wr_en = accept;
				end else if (opcode == OP_PUSH_FRONT) begin
					front_d     = wrap_prev(front_q);
					req.wr_addr = front_d;
					req.wr_en   = accept;
				end else begin
					rear_d      = wrap_next(rear_q);
					req.wr_addr = rear_d;
					req.wr_en   = accept;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (empty_q) begin
					req.status = ST_UNDERFLOW;
				end else if (last_one) begin
					empty_d = 1'b1;
					front_d = '0;
					rear_d  = '0;
				end else if (opcode == OP_POP_FRONT) begin
					front_d = wrap_next(front_q);
				end else begin
					rear_d = wrap_prev(rear_q);
				end
			end
			OP_PEEK_FRONT, OP_PEEK_REAR: begin
				if (empty_q) begin
					req.status = ST_UNDERFLOW;
				end else begin
					req.rd_en   = accept;
					req.rd_addr = (opcode == OP_PEEK_FRONT) ? front_q : rear_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			empty_q <= empty_d;
		end
	end

	// An empty deque always parks both pointers at entry zero.
	a_empty_parks: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty deque with pointers away from zero");

	// One operation touches the ring at most once.
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en))
		else $error("ring write and read in the same operation");

	// A stored push leaves the deque non-empty.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> !empty_q)
		else $error("deque empty after a push");

	// Overflow is only reported for pushes.
	a_ovf_push: assert property (@(posedge clk) disable iff (!arst_n)
		(req.status == ST_OVERFLOW) |->
			(opcode == OP_PUSH_FRONT || opcode == OP_PUSH_REAR))
		else $error("overflow on a non-push operation");

	// A full deque never grows.
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_REAR))
			|=> ($stable(front_q) && $stable(rear_q)))
		else $error("pointers moved on a refused push");

endmodule

// ===== rtl/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue on a ring memory
// Top level: handshake, pointer control, ring memory and result register.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall) carries one operation word: an opcode
//   (push front, push rear, pop front, pop rear, peek front, peek rear) and
//   push_data. Every accepted word produces exactly one result word on the
//   output channel (out_valid / out_stall): read_data and status.
//   The result of an operation accepted at one edge is presented from the
//   next cycle on; the registered read port of the ring memory holds the
//   peeked word.
//   Throughput is one operation per cycle while out_stall is low. Pointer
//   updates and the ring write or read (if any) of each operation complete at
//   the accepting edge, so back-to-back operations never collide on an entry.
//   When the receiver stalls, the pending result stays in the result register
//   and in_stall is raised, so no further operation is taken until the
//   result is removed; a result taken in the same cycle frees the slot at once.
//   Reset (arst_n low) empties the deque and clears both pointers and the
//   output valid flag. Ring contents are not cleared; only live entries can
//   ever be peeked.
//   A push to a full deque reports overflow and changes nothing. A pop or
//   peek on an empty deque reports underflow with read_data zero.
// ----------------------------------------------------------------------------
module circular_deque import cdq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] push_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic [1:0]  status
);

	ring_req_t req;
	logic      accept;
	word_t     ring_rd_data;

	logic      out_valid_q;
	status_t   status_q;
	logic      peek_ok_q;

	// The result register is the only buffer: a new word can enter whenever
	// the slot is empty or its occupant leaves at this edge.
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.opcode (opcode),
		.req    (req)
	);

	cdq_ring_ram #(
		.Depth (DEPTH),
		.Width (DATA_WIDTH)
	) u_ring (
		.clk     (clk),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr),
		.wr_data (to_store(push_data)),
		.rd_en   (req.rd_en),
		.rd_addr (req.rd_addr),
		.rd_data (ring_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Status and the peek flag travel alongside the memory's read register;
	// the memory only reloads on a successful peek, so the flag selects it.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= req.status;
			peek_ok_q <= req.rd_en;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_data = peek_ok_q ? from_store(ring_rd_data) : 32'd0;

endmodule
